// ===== rtl/wpm_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Wildcard pattern matcher package
// Shared constants, command codes and the control struct broadcast to cells.
// ----------------------------------------------------------------------------
package wpm_pkg;

    localparam int PATTERN_MAX_DEF = 32;

    localparam int SYM_W    = 8;
    localparam int CMD_W    = 2;
    localparam int STATUS_W = 2;
    localparam int USED_W   = 6;

    // Command codes carried on the input tuser.
    localparam logic [CMD_W-1:0] CMD_CLEAR  = 2'd0;
    localparam logic [CMD_W-1:0] CMD_APPEND = 2'd1;
    localparam logic [CMD_W-1:0] CMD_TEXT   = 2'd2;

    // Status codes in the result.
    localparam logic [STATUS_W-1:0] ST_OK         = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL       = 2'd1;
    localparam logic [STATUS_W-1:0] ST_AFTER_TEXT = 2'd2;
    localparam logic [STATUS_W-1:0] ST_UNUSED     = 2'd3;

    // Wildcard symbols.
    localparam logic [SYM_W-1:0] SYM_STAR  = 8'h2A;
    localparam logic [SYM_W-1:0] SYM_QMARK = 8'h3F;

    // Result tdata layout, lowest bit first.
    localparam int OUT_MATCHED_LSB = 0;
    localparam int OUT_STATUS_LSB  = 1;
    localparam int OUT_USED_LSB    = 3;
    localparam int OUT_DATA_W      = 16;

    // Operation broadcast to every cell in the chain.
    typedef struct packed {
        logic             clear;
        logic             append;
        logic             text;
        logic [SYM_W-1:0] sym;
    } cell_ctrl_t;

endpackage

// ===== rtl/wpm_cell.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Wildcard pattern matcher cell
// Holds one pattern symbol and its prefix match bit, and updates that bit
// from its left neighbor's old and new bits.
// ----------------------------------------------------------------------------
module wpm_cell (
    input  logic                      aclk,
    input  wpm_pkg::cell_ctrl_t       ctrl,
    input  logic                      sel_append,
    input  logic                      active,
    input  logic                      left_old,
    input  logic                      left_new,
    output logic                      bit_old,
    output logic                      bit_new
);

    logic [wpm_pkg::SYM_W-1:0] sym_reg;
    logic [wpm_pkg::SYM_W-1:0] sym_next;
    logic                      bit_reg;
    logic                      bit_next;
    logic                      is_star;
    logic                      hit;
    logic                      text_val;

    assign is_star  = (sym_reg == wpm_pkg::SYM_STAR);
    assign hit      = (sym_reg == wpm_pkg::SYM_QMARK) || (sym_reg == ctrl.sym);
    // A star extends any match of the shorter prefix, including over the
    // current text symbol; other symbols consume exactly one text symbol.
    assign text_val = is_star ? (bit_reg | left_new) : (hit & left_old);

    always_comb begin
        sym_next = sym_reg;
        bit_next = bit_reg;
        if (ctrl.clear) begin
            bit_next = 1'b0;
        end else if (ctrl.append && sel_append) begin
            sym_next = ctrl.sym;
            bit_next = left_old && (ctrl.sym == wpm_pkg::SYM_STAR);
        end else if (ctrl.text && active) begin
            bit_next = text_val;
        end
    end

    // The symbol store has no reset; unwritten cells stay inactive.
    always_ff @(posedge aclk) begin
        sym_reg <= sym_next;
    end

    // The match bit is written by the append that fills this cell before it
    // is ever read, so it needs no reset either.
    always_ff @(posedge aclk) begin
        bit_reg <= bit_next;
    end

    assign bit_old = bit_reg;
    assign bit_new = bit_next;

endmodule

// ===== rtl/wildcard_pattern_matcher.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Wildcard pattern matcher
// Glob matcher with '?' and '*', built as a chain of one cell per pattern
// position.
// ----------------------------------------------------------------------------
// Usage:
//   Every input transaction carries a command on s_axis_tuser and a byte on
//   s_axis_tdata. A clear command starts a new match, append commands load
//   pattern symbols one by one, and text commands stream the text. Every
//   input transaction produces exactly one result transaction on the m_axis
//   side, holding the matched flag, a status code and the pattern length.
//   The chain holds one cell per pattern position. Each cell keeps its
//   pattern symbol and the bit saying whether that pattern prefix matches
//   the text so far. On a text symbol all cells update in the same cycle;
//   a star takes its left neighbor's new bit, others its old bit, so one
//   transaction is accepted per cycle unless the output stalls and the
//   result appears in the cycle after. Chain depth sets the longest path.
//   The result sits in an output register; s_axis_tready stays high while
//   that register is empty or being drained, so a stalled receiver holds the
//   current result stable and stops new input after one transaction.
//   After reset the pattern is empty, the row is reset to match the empty
//   text, and no result is pending. Unwritten pattern cells are never read.
// ----------------------------------------------------------------------------
module wildcard_pattern_matcher #(
    parameter int PATTERN_MAX = wpm_pkg::PATTERN_MAX_DEF
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    // Bits [7:0]: symbol.
    input  logic [7:0]                     s_axis_tdata,
    // Bits [1:0]: cmd.
    input  logic [wpm_pkg::CMD_W-1:0]      s_axis_tuser,
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    // Bit 0: matched, bits [2:1]: status, bits [8:3]: pattern_used,
    // bits [15:9]: zero.
    output logic [wpm_pkg::OUT_DATA_W-1:0] m_axis_tdata
);

    localparam int CNT_W = $clog2(PATTERN_MAX + 1);

    logic                          in_accept;
    logic                          out_accept;
    logic [wpm_pkg::CMD_W-1:0]     cmd;
    logic                          is_append;
    logic                          is_full;
    logic [wpm_pkg::STATUS_W-1:0]  status;
    wpm_pkg::cell_ctrl_t           ctrl;

    logic [CNT_W-1:0]              count_reg;
    logic [CNT_W-1:0]              count_next;
    logic                          text_begun_reg;
    logic                          text_begun_next;
    logic                          row0_reg;
    logic                          row0_next;

    logic [PATTERN_MAX:0]          row_old;
    logic [PATTERN_MAX:0]          row_new;
    logic                          matched;
    logic [CNT_W+wpm_pkg::USED_W-1:0] used_ext;

    logic                          m_valid_reg;
    logic                          m_valid_next;
    logic [wpm_pkg::OUT_DATA_W-1:0] m_data_reg;
    logic [wpm_pkg::OUT_DATA_W-1:0] m_data_next;

    assign s_axis_tready = !m_valid_reg || m_axis_tready;
    assign in_accept     = s_axis_tvalid && s_axis_tready;
    assign out_accept    = m_valid_reg && m_axis_tready;
    assign cmd           = s_axis_tuser;

    assign is_append = in_accept && (cmd == wpm_pkg::CMD_APPEND);
    assign is_full   = (count_reg >= CNT_W'(PATTERN_MAX));

    // An append after text has begun is checked before the full store.
    always_comb begin
        status = wpm_pkg::ST_OK;
        if (is_append) begin
            priority if (text_begun_reg) begin
                status = wpm_pkg::ST_AFTER_TEXT;
            end else if (is_full) begin
                status = wpm_pkg::ST_FULL;
            end
        end
    end

    assign ctrl.clear  = in_accept && (cmd == wpm_pkg::CMD_CLEAR);
    assign ctrl.append = is_append && (status == wpm_pkg::ST_OK);
    assign ctrl.text   = in_accept && (cmd == wpm_pkg::CMD_TEXT);
    assign ctrl.sym    = s_axis_tdata;

    // Bit zero of the row: the empty pattern matches only the empty text.
    always_comb begin
        row0_next = row0_reg;
        if (ctrl.clear) begin
            row0_next = 1'b1;
        end else if (ctrl.text) begin
            row0_next = 1'b0;
        end
    end

    always_comb begin
        count_next      = count_reg;
        text_begun_next = text_begun_reg;
        if (ctrl.clear) begin
            count_next      = '0;
            text_begun_next = 1'b0;
        end else if (ctrl.append) begin
            count_next = count_reg + CNT_W'(1);
        end else if (ctrl.text) begin
            text_begun_next = 1'b1;
        end
    end

    assign row_old[0] = row0_reg;
    assign row_new[0] = row0_next;

    for (genvar k = 0; k < PATTERN_MAX; k++) begin : g_cell
        wpm_cell u_cell (
            .aclk       (aclk),
            .ctrl       (ctrl),
            .sel_append (count_reg == CNT_W'(k)),
            .active     (CNT_W'(k) < count_reg),
            .left_old   (row_old[k]),
            .left_new   (row_new[k]),
            .bit_old    (row_old[k+1]),
            .bit_new    (row_new[k+1])
        );
    end

    assign matched  = row_new[count_next];
    assign used_ext = {{wpm_pkg::USED_W{1'b0}}, count_next};

    always_comb begin
        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;
        if (in_accept) begin
            m_valid_next = 1'b1;
            m_data_next  = '0;
            m_data_next[wpm_pkg::OUT_MATCHED_LSB] = matched;
            m_data_next[wpm_pkg::OUT_STATUS_LSB +: wpm_pkg::STATUS_W] = status;
            m_data_next[wpm_pkg::OUT_USED_LSB +: wpm_pkg::USED_W] =
                used_ext[wpm_pkg::USED_W-1:0];
        end else if (out_accept) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg      <= '0;
            text_begun_reg <= 1'b0;
            row0_reg       <= 1'b1;
            m_valid_reg    <= 1'b0;
        end else begin
            count_reg      <= count_next;
            text_begun_reg <= text_begun_next;
            row0_reg       <= row0_next;
            m_valid_reg    <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_data_reg <= m_data_next;
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = m_data_reg;

endmodule

// ===== rtl/wpm_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Wildcard pattern matcher checker
// Port-level assertions on result content and stability, bound to the top.
// ----------------------------------------------------------------------------
module wpm_checker (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_axis_tvalid,
    input  logic                           s_axis_tready,
    input  logic [wpm_pkg::CMD_W-1:0]      s_axis_tuser,
    input  logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    input  logic [wpm_pkg::OUT_DATA_W-1:0] m_axis_tdata
);

    logic in_acc;

    assign in_acc = s_axis_tvalid && s_axis_tready;

    // A clear reports an empty match on an empty pattern in the next cycle.
    a_clear_result: assert property (@(posedge aclk) disable iff (!aresetn)
        in_acc && (s_axis_tuser == wpm_pkg::CMD_CLEAR) |=>
            m_axis_tvalid && m_axis_tdata[wpm_pkg::OUT_MATCHED_LSB] &&
            (m_axis_tdata[wpm_pkg::OUT_STATUS_LSB +: wpm_pkg::STATUS_W] ==
             wpm_pkg::ST_OK) &&
            (m_axis_tdata[wpm_pkg::OUT_USED_LSB +: wpm_pkg::USED_W] == '0))
        else $error("clear did not return an empty match");

    // Text transactions never report an error status.
    a_text_ok: assert property (@(posedge aclk) disable iff (!aresetn)
        in_acc && (s_axis_tuser == wpm_pkg::CMD_TEXT) |=>
            (m_axis_tdata[wpm_pkg::OUT_STATUS_LSB +: wpm_pkg::STATUS_W] ==
             wpm_pkg::ST_OK))
        else $error("text transaction reported a bad status");

    // A text transaction leaves the pattern length as it was.
    a_text_len: assert property (@(posedge aclk) disable iff (!aresetn)
        in_acc && (s_axis_tuser == wpm_pkg::CMD_TEXT) && m_axis_tvalid |=>
            (m_axis_tdata[wpm_pkg::OUT_USED_LSB +: wpm_pkg::USED_W] ==
             $past(m_axis_tdata[wpm_pkg::OUT_USED_LSB +: wpm_pkg::USED_W])))
        else $error("text transaction changed the pattern length");

    // A stalled result holds its payload.
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("stalled result changed");

endmodule

bind wildcard_pattern_matcher wpm_checker u_wpm_checker (
    .aclk          (aclk),
    .aresetn       (aresetn),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

// ===== bench/tb_wildcard_pattern_matcher.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Testbench for the wildcard pattern matcher
// Streams clear, pattern append and text commands into the matcher and checks
// every result transaction against a bit-row glob predictor kept in the bench.
// The stimulus opens with a directed set of corner cases. Random match
// sequences follow, mostly well formed with some noise mixed in, under
// changing amounts of sender and receiver idling and one long receiver stall.
// ----------------------------------------------------------------------------
module tb_wildcard_pattern_matcher;

    localparam int PATTERN_MAX = wpm_pkg::PATTERN_MAX_DEF;

    typedef logic [wpm_pkg::CMD_W-1:0]  cmd_t;
    typedef logic [wpm_pkg::SYM_W-1:0]  sym_t;
    typedef logic [wpm_pkg::USED_W-1:0] used_t;

    // The input channel also carries a fourth command code, which the block
    // must ignore. The package has no name for it.
    localparam cmd_t CMD_IGNORED = 2'd3;

    // Random items are queued in two chunks, with a full drain in between.
    localparam int RANDOM_ITEMS = 400;
    localparam int CHUNK_ITEMS  = 200;

    // Idling profile boundaries, counted in accepted input transactions.
    localparam int PHASE1_END = 200;
    localparam int PHASE2_END = 400;

    // The receiver stops for a long stretch once this many results arrived.
    localparam int STALL_AT_RESULT = 60;
    localparam int STALL_CYCLES    = 300;

    // Margin waited after the final drain before checking for missing results.
    localparam int DRAIN_CYCLES = 10;
    localparam int CYCLE_LIMIT  = 200000;

    typedef struct packed {
        cmd_t cmd;
        sym_t sym;
    } match_cmd_t;

    typedef struct packed {
        logic                         matched;
        logic [wpm_pkg::STATUS_W-1:0] status;
        used_t                        used;
    } match_result_t;

    logic aclk;
    logic aresetn = 1'b0;

    logic                           s_axis_tvalid = 1'b0;
    logic                           s_axis_tready;
    // Bits [7:0]: symbol.
    logic [7:0]                     s_axis_tdata  = '0;
    // Bits [1:0]: cmd.
    cmd_t                           s_axis_tuser  = wpm_pkg::CMD_CLEAR;
    logic                           m_axis_tvalid;
    logic                           m_axis_tready = 1'b0;
    // Bit 0: matched, bits [2:1]: status, bits [8:3]: pattern_used.
    logic [wpm_pkg::OUT_DATA_W-1:0] m_axis_tdata;

    // Commands waiting to be offered, and results the block still owes us.
    match_cmd_t    pending_q[$];
    match_result_t expected_q[$];

    // Predictor state: the stored pattern, its length, the prefix match row
    // (bit j set when the first j pattern symbols match the text so far) and
    // whether text has started since the last clear.
    sym_t                 pattern_mem[PATTERN_MAX];
    int                   pattern_len  = 0;
    logic [PATTERN_MAX:0] prefix_row   = 1;
    logic                 text_started = 1'b0;

    int items_queued   = 0;
    int items_accepted = 0;
    int results_seen   = 0;
    int error_count    = 0;
    int stall_left     = 0;
    bit stall_done     = 1'b0;
    int cycle_count    = 0;

    match_cmd_t    next_item;
    match_result_t got_result;
    match_result_t want_result;

    wildcard_pattern_matcher #(
        .PATTERN_MAX(PATTERN_MAX)
    ) u_top (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always begin
        aclk = 1'b1;
        #5;
        aclk = 1'b0;
        #5;
    end

    // ------------------------------------------------------------------------
    // Glob predictor. Advances the bench's copy of the matcher state by one
    // command and returns the result the block must produce for it.
    // ------------------------------------------------------------------------
    function automatic match_result_t predict_match(input cmd_t cmd,
                                                    input sym_t sym);
        match_result_t res;
        logic          left_old;
        logic          here_old;
        res.status = wpm_pkg::ST_OK;
        case (cmd)
            wpm_pkg::CMD_CLEAR: begin
                pattern_len  = 0;
                prefix_row   = 1;
                text_started = 1'b0;
            end
            wpm_pkg::CMD_APPEND: begin
                // Text already seen takes priority over a full store.
                if (text_started) begin
                    res.status = wpm_pkg::ST_AFTER_TEXT;
                end else if (pattern_len >= PATTERN_MAX) begin
                    res.status = wpm_pkg::ST_FULL;
                end else begin
                    // With no text yet, a new prefix matches only if the
                    // shorter one did and the new symbol is a star.
                    pattern_mem[pattern_len]    = sym;
                    prefix_row[pattern_len + 1] = prefix_row[pattern_len] &&
                                                  (sym == wpm_pkg::SYM_STAR);
                    pattern_len++;
                end
            end
            wpm_pkg::CMD_TEXT: begin
                text_started = 1'b1;
                // Walk the row left to right. A star takes the old bit at its
                // own position (star absorbs this symbol) or the new bit to
                // its left (star matches an empty run). Any other pattern
                // symbol takes the old bit of its left neighbor if it matches.
                left_old      = prefix_row[0];
                prefix_row[0] = 1'b0;
                for (int j = 1; j <= pattern_len; j++) begin
                    here_old = prefix_row[j];
                    if (pattern_mem[j - 1] == wpm_pkg::SYM_STAR) begin
                        prefix_row[j] = here_old | prefix_row[j - 1];
                    end else if (pattern_mem[j - 1] == wpm_pkg::SYM_QMARK ||
                                 pattern_mem[j - 1] == sym) begin
                        prefix_row[j] = left_old;
                    end else begin
                        prefix_row[j] = 1'b0;
                    end
                    left_old = here_old;
                end
            end
            default: begin
                // The unused command code leaves everything untouched.
            end
        endcase
        res.matched = prefix_row[pattern_len];
        res.used    = used_t'(pattern_len);
        return res;
    endfunction

    task automatic report_error(input string msg);
        $display("ERROR at %0t ns: %s", $time, msg);
        error_count++;
    endtask

    task automatic push_item(input cmd_t cmd, input sym_t sym);
        match_cmd_t item;
        item.cmd = cmd;
        item.sym = sym;
        pending_q.push_back(item);
        items_queued++;
    endtask

    // Idle percentage of either side for the current idling profile: first a
    // busy sender with a lazy receiver, then the reverse, then no idling.
    function automatic int idle_pct(input bit receiver_side);
        if (items_accepted < PHASE1_END) begin
            return receiver_side ? 68 : 6;
        end
        if (items_accepted < PHASE2_END) begin
            return receiver_side ? 6 : 68;
        end
        return 0;
    endfunction

    // ------------------------------------------------------------------------
    // One match sequence: a clear, a pattern, then text derived from that
    // pattern so that a good share of the sequences end in a match. When
    // want_match is low the text is damaged in one place. Some sequences end
    // with a late append or the ignored command.
    // ------------------------------------------------------------------------
    task automatic queue_sequence(input int pat_count, input bit want_match);
        sym_t pat[$];
        sym_t text[$];
        sym_t s;
        int   pos;
        push_item(wpm_pkg::CMD_CLEAR, sym_t'($urandom));
        for (int k = 0; k < pat_count; k++) begin
            case ($urandom_range(9))
                0, 1, 2: s = wpm_pkg::SYM_STAR;
                3, 4:    s = wpm_pkg::SYM_QMARK;
                5:       s = sym_t'($urandom);
                default: s = sym_t'(8'h61 + $urandom_range(2));
            endcase
            pat.push_back(s);
            push_item(wpm_pkg::CMD_APPEND, s);
        end
        // Appends beyond the store are rejected, so the text follows only the
        // symbols that were kept.
        while (pat.size() > PATTERN_MAX) begin
            void'(pat.pop_back());
        end
        foreach (pat[j]) begin
            if (pat[j] == wpm_pkg::SYM_STAR) begin
                repeat ($urandom_range(3)) text.push_back(sym_t'(8'h61 + $urandom_range(2)));
            end else if (pat[j] == wpm_pkg::SYM_QMARK) begin
                text.push_back(sym_t'($urandom));
            end else begin
                text.push_back(pat[j]);
            end
        end
        if (!want_match) begin
            pos = (text.size() == 0) ? 0 : $urandom_range(text.size() - 1);
            case ($urandom_range(2))
                0: text.insert(pos, sym_t'(8'h61 + $urandom_range(2)));
                1: if (text.size() != 0) text.delete(pos);
                default: if (text.size() != 0) text[pos] = sym_t'($urandom);
            endcase
        end
        foreach (text[j]) begin
            push_item(wpm_pkg::CMD_TEXT, text[j]);
        end
        if ($urandom_range(4) == 0) begin
            push_item(wpm_pkg::CMD_APPEND, sym_t'($urandom));
        end
        if ($urandom_range(9) == 0) begin
            push_item(CMD_IGNORED, sym_t'($urandom));
        end
    endtask

    // Queues random sequences until the given number of items is reached.
    // Most are well formed; one in ten is a burst of arbitrary commands, and
    // one in eight of the rest uses a long pattern that may overflow the store.
    task automatic queue_random(input int count, input bit start_full);
        int base;
        base = items_queued;
        if (start_full) begin
            queue_sequence(PATTERN_MAX + 2, 1'b1);
        end
        while (items_queued - base < count) begin
            if ($urandom_range(9) == 0) begin
                repeat ($urandom_range(8, 1)) begin
                    push_item(cmd_t'($urandom_range(3)), sym_t'($urandom));
                end
            end else if ($urandom_range(7) == 0) begin
                queue_sequence($urandom_range(PATTERN_MAX + 2, 16), $urandom_range(1) != 0);
            end else begin
                queue_sequence($urandom_range(8), $urandom_range(3) != 0);
            end
        end
    endtask

    task automatic wait_for_drain();
        while (pending_q.size() != 0 || s_axis_tvalid || expected_q.size() != 0) begin
            @(posedge aclk);
        end
    endtask

    // ------------------------------------------------------------------------
    // Driver. On an accepted transaction the predictor runs and the expected
    // result is stored. A new item is offered only once the current one is
    // gone, so tvalid never drops while a transaction is pending.
    // ------------------------------------------------------------------------
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_axis_tvalid <= 1'b0;
        end else begin
            if (s_axis_tvalid && s_axis_tready) begin
                expected_q.push_back(predict_match(s_axis_tuser, s_axis_tdata));
                items_accepted++;
            end
            if (!s_axis_tvalid || s_axis_tready) begin
                if (pending_q.size() != 0 && $urandom_range(99) >= idle_pct(1'b0)) begin
                    next_item = pending_q.pop_front();
                    s_axis_tvalid <= 1'b1;
                    s_axis_tuser  <= next_item.cmd;
                    s_axis_tdata  <= next_item.sym;
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Long receiver stall. Once enough results have arrived the receiver
    // holds off once, so that the output register fills and input backs up.
    // ------------------------------------------------------------------------
    always @(posedge aclk) begin
        if (!aresetn) begin
            stall_left <= 0;
        end else if (stall_left > 0) begin
            stall_left <= stall_left - 1;
        end else if (!stall_done && results_seen >= STALL_AT_RESULT) begin
            stall_done <= 1'b1;
            stall_left <= STALL_CYCLES;
        end
    end

    // ------------------------------------------------------------------------
    // Monitor. Each result transaction is unpacked and compared field by
    // field with the oldest expectation.
    // ------------------------------------------------------------------------
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_axis_tready <= 1'b0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                got_result.matched = m_axis_tdata[wpm_pkg::OUT_MATCHED_LSB];
                got_result.status  =
                    m_axis_tdata[wpm_pkg::OUT_STATUS_LSB +: wpm_pkg::STATUS_W];
                got_result.used    = m_axis_tdata[wpm_pkg::OUT_USED_LSB +: wpm_pkg::USED_W];
                results_seen++;
                if (expected_q.size() == 0) begin
                    report_error($sformatf("unexpected result 0x%0h", m_axis_tdata));
                end else begin
                    want_result = expected_q.pop_front();
                    if (got_result.matched !== want_result.matched) begin
                        report_error($sformatf("result %0d: matched %0b, expected %0b",
                                               results_seen, got_result.matched,
                                               want_result.matched));
                    end
                    if (got_result.status !== want_result.status) begin
                        report_error($sformatf("result %0d: status %0d, expected %0d",
                                               results_seen, got_result.status,
                                               want_result.status));
                    end
                    if (got_result.used !== want_result.used) begin
                        report_error($sformatf("result %0d: pattern_used %0d, expected %0d",
                                               results_seen, got_result.used,
                                               want_result.used));
                    end
                end
            end
            if (stall_left > 0) begin
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= ($urandom_range(99) >= idle_pct(1'b1));
            end
        end
    end

    // Watchdog: a hung handshake ends the run as a failure.
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus and end of test.
    // ------------------------------------------------------------------------
    initial begin
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;

        // Text against an empty pattern, then the ignored command.
        push_item(wpm_pkg::CMD_CLEAR,  8'h00);
        push_item(wpm_pkg::CMD_TEXT,   8'h00);
        push_item(CMD_IGNORED,         8'hFF);
        // Stars match the empty text; a literal star in the text is an
        // ordinary byte that a pattern star still absorbs.
        push_item(wpm_pkg::CMD_CLEAR,  8'hFF);
        push_item(wpm_pkg::CMD_APPEND, wpm_pkg::SYM_STAR);
        push_item(wpm_pkg::CMD_APPEND, wpm_pkg::SYM_STAR);
        push_item(wpm_pkg::CMD_APPEND, 8'hFF);
        push_item(wpm_pkg::CMD_APPEND, wpm_pkg::SYM_QMARK);
        push_item(wpm_pkg::CMD_TEXT,   wpm_pkg::SYM_STAR);
        push_item(wpm_pkg::CMD_TEXT,   8'hFF);
        push_item(wpm_pkg::CMD_TEXT,   8'h00);
        push_item(wpm_pkg::CMD_TEXT,   wpm_pkg::SYM_QMARK);
        // Append once text has begun is rejected.
        push_item(wpm_pkg::CMD_APPEND, 8'h00);
        push_item(CMD_IGNORED,         8'h00);
        // A text question mark is matched by a pattern question mark.
        push_item(wpm_pkg::CMD_CLEAR,  8'h00);
        push_item(wpm_pkg::CMD_APPEND, wpm_pkg::SYM_QMARK);
        push_item(wpm_pkg::CMD_TEXT,   wpm_pkg::SYM_QMARK);
        push_item(wpm_pkg::CMD_TEXT,   8'h7F);
        // A plain literal matches once and fails on more text.
        push_item(wpm_pkg::CMD_CLEAR,  8'h00);
        push_item(wpm_pkg::CMD_APPEND, 8'h61);
        push_item(wpm_pkg::CMD_TEXT,   8'h61);
        push_item(wpm_pkg::CMD_TEXT,   8'h61);
        wait_for_drain();

        // The first random sequence overflows the store on purpose.
        queue_random(CHUNK_ITEMS, 1'b1);
        // Sender pauses here until every outstanding result has come back.
        wait_for_drain();
        queue_random(RANDOM_ITEMS - CHUNK_ITEMS, 1'b0);
        wait_for_drain();
        repeat (DRAIN_CYCLES) @(posedge aclk);

        if (expected_q.size() != 0) begin
            report_error($sformatf("%0d results never arrived", expected_q.size()));
        end
        if (error_count == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/wpm_pkg.sv
rtl/wpm_cell.sv
rtl/wildcard_pattern_matcher.sv
rtl/wpm_checker.sv
bench/tb_wildcard_pattern_matcher.sv
